// ===== rtl/core/assert_macros.svh =====
// assertion helper macros for the track lifecycle block
// used by the top level only, no other dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/core/stlf_pkg.sv =====
// shared types, codes and helpers for the track lifecycle block
// no dependencies
package stlf_pkg;

    localparam int TRACKS    = 4;
    localparam int BUF_BYTES = 8192;
    localparam int LVL_W     = 14;
    localparam int LVL_CMP_W = 17;

    // event codes
    typedef enum logic [3:0] {
        REQ_START  = 4'd0,
        REQ_LEVEL  = 4'd1,
        REQ_EOF    = 4'd2,
        REQ_CLOSED = 4'd3,
        REQ_PAUSE  = 4'd4,
        REQ_RESUME = 4'd5,
        REQ_TOGGLE = 4'd6,
        REQ_STOP   = 4'd7,
        REQ_STATUS = 4'd8
    } t_req;

    // buffering and closing phases
    typedef enum logic [2:0] {
        PH_RD_EMPTY = 3'd0,
        PH_RD_PART  = 3'd1,
        PH_WT_FULL  = 3'd2,
        PH_WT_EOF   = 3'd3,
        PH_CL_PART  = 3'd4,
        PH_CL_EMPTY = 3'd5,
        PH_CD_PART  = 3'd6,
        PH_CD_EMPTY = 3'd7
    } t_phase;

    // visible status codes
    typedef enum logic [1:0] {
        ST_STOPPED   = 2'd0,
        ST_BUFFERING = 2'd1,
        ST_PLAYING   = 2'd2,
        ST_PAUSED    = 2'd3
    } t_status;

    // per-slot state
    typedef struct packed {
        logic   busy;
        t_phase phase;
        logic   paused;
        logic   restart;
    } t_slot;

    // one result beat
    typedef struct packed {
        logic    issue_read;
        logic    stop_source;
        logic    flush_buffer;
        logic    request_close;
        logic    release_slot;
        logic    restart_requested;
        logic    notify_change;
        logic    wake_mixer;
        logic    invalid_event;
        t_status track_status;
    } t_act;

    localparam t_slot SLOT_FREE = '{busy: 1'b0, phase: PH_RD_EMPTY,
                                    paused: 1'b0, restart: 1'b0};

    function automatic logic has_audio(input t_phase ph);
        return (ph == PH_RD_PART) || (ph == PH_WT_FULL) ||
               (ph == PH_CL_PART) || (ph == PH_CD_PART);
    endfunction

    function automatic t_status status_of(input t_slot s);
        t_status st;
        st = ST_STOPPED;
        if (s.busy) begin
            if (s.phase == PH_RD_EMPTY) begin
                st = s.paused ? ST_PAUSED : ST_BUFFERING;
            end else if (has_audio(s.phase)) begin
                st = s.paused ? ST_PAUSED : ST_PLAYING;
            end
        end
        return st;
    endfunction

endpackage

// ===== rtl/core/stream_track_lifecycle_fsm_unit.sv =====
// top level of the track lifecycle block: input register, slot table, result register
// depends on stlf_pkg, stlf_event_logic and assert_macros.svh
//
// Usage:
//   Input channel: i_in_valid with i_req_type, i_track, i_fill_level; a beat is
//   taken at a rising edge with i_in_valid high and o_in_stall low.
//   Output channel: o_out_valid with the action strobes and o_track_status; a
//   beat is delivered at a rising edge with o_out_valid high and i_out_stall low.
//   Result path: a taken beat lands in the input register, then decode and slot
//   table update load the result register, whose contents drive the outputs.
//   Throughput: one event per cycle while the receiver does not stall; the slot
//   table is read and written in the same cycle, so each event sees the state the previous one left.
//   Stall: when the receiver stalls, the result register holds and one more
//   event waits in the input register; o_in_stall rises only when both are full.
//   Reset: i_rst_n low at a rising edge empties both registers and frees every
//   slot (phase reading/empty, no pause, no restart).
`include "assert_macros.svh"
module stream_track_lifecycle_fsm_unit
    import stlf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [3:0]       i_req_type,
    input  logic [1:0]       i_track,
    input  logic [LVL_W-1:0] i_fill_level,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic             o_issue_read,
    output logic             o_stop_source,
    output logic             o_flush_buffer,
    output logic             o_request_close,
    output logic             o_release_slot,
    output logic             o_restart_requested,
    output logic             o_notify_change,
    output logic             o_wake_mixer,
    output logic             o_invalid_event,
    output logic [1:0]       o_track_status
);

    logic             r_in_valid;
    logic [3:0]       r_req;
    logic [1:0]       r_trk;
    logic [LVL_W-1:0] r_lvl;
    t_slot            r_slot [TRACKS];
    logic             r_out_valid;
    t_act             r_act;

    logic  out_free;
    logic  advance;
    logic  take_in;
    logic  trk_ok;
    logic  slot_wr;
    t_slot cur_slot;
    t_slot n_slot;
    t_act  n_act;
    logic  n_in_valid;
    logic  n_out_valid;

    // pipeline handshake
    assign out_free    = !r_out_valid || !i_out_stall;
    assign advance     = r_in_valid && out_free;
    assign o_in_stall  = r_in_valid && !out_free;
    assign take_in     = i_in_valid && !o_in_stall;
    assign n_in_valid  = take_in || (r_in_valid && !advance);
    assign n_out_valid = advance || (r_out_valid && i_out_stall);

    // slot lookup
    assign trk_ok   = int'(r_trk) < TRACKS;
    assign cur_slot = trk_ok ? r_slot[r_trk] : SLOT_FREE;

    stlf_event_logic u_evt (
        .i_slot       (cur_slot),
        .i_req_type   (r_req),
        .i_track_ok   (trk_ok),
        .i_fill_level (r_lvl),
        .o_slot_next  (n_slot),
        .o_write      (slot_wr),
        .o_act        (n_act)
    );

    // control registers and slot table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < TRACKS; k++) begin
                r_slot[k] <= SLOT_FREE;
            end
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            if (advance && slot_wr) begin
                r_slot[r_trk] <= n_slot;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_req <= i_req_type;
            r_trk <= i_track;
            r_lvl <= i_fill_level;
        end
        if (advance) begin
            r_act <= n_act;
        end
    end

    // result ports
    assign o_out_valid         = r_out_valid;
    assign o_issue_read        = r_act.issue_read;
    assign o_stop_source       = r_act.stop_source;
    assign o_flush_buffer      = r_act.flush_buffer;
    assign o_request_close     = r_act.request_close;
    assign o_release_slot      = r_act.release_slot;
    assign o_restart_requested = r_act.restart_requested;
    assign o_notify_change     = r_act.notify_change;
    assign o_wake_mixer        = r_act.wake_mixer;
    assign o_invalid_event     = r_act.invalid_event;
    assign o_track_status      = r_act.track_status;

    // checks
    `ASSERT_SAME(a_restart_with_release, i_clk, i_rst_n,
        o_out_valid && o_restart_requested, o_release_slot)
    `ASSERT_SAME(a_invalid_alone, i_clk, i_rst_n,
        o_out_valid && o_invalid_event,
        !o_issue_read && !o_stop_source && !o_flush_buffer && !o_request_close &&
        !o_release_slot && !o_notify_change && !o_wake_mixer)
    `ASSERT_SAME(a_release_stopped, i_clk, i_rst_n,
        o_out_valid && o_release_slot, o_track_status == ST_STOPPED)
    `ASSERT_NEXT(a_held_result, i_clk, i_rst_n,
        o_out_valid && i_out_stall, o_out_valid && $stable(r_act))

endmodule

// ===== rtl/core/stlf_event_logic.sv =====
// next-state and action decode for one event on one slot
// depends on stlf_pkg
module stlf_event_logic
    import stlf_pkg::*;
(
    input  t_slot              i_slot,
    input  logic [3:0]         i_req_type,
    input  logic               i_track_ok,
    input  logic [LVL_W-1:0]   i_fill_level,
    output t_slot              o_slot_next,
    output logic               o_write,
    output t_act               o_act
);

    localparam logic [LVL_CMP_W-1:0] BUF_LIM = LVL_CMP_W'(BUF_BYTES);

    logic  lvl_full;
    logic  lvl_empty;
    logic  ok;
    t_slot ns;
    t_act  na;

    // release returns the slot to free and reports the pending restart
    function automatic void do_release(input t_slot s, inout t_slot n, inout t_act a);
        a.release_slot      = 1'b1;
        a.restart_requested = s.restart;
        n                   = SLOT_FREE;
    endfunction

    function automatic void do_stop(input t_slot s, inout t_slot n, inout t_act a);
        if (s.phase == PH_RD_EMPTY || s.phase == PH_RD_PART) begin
            a.stop_source  = 1'b1;
            a.flush_buffer = 1'b1;
            n.phase        = PH_WT_EOF;
        end else if (s.phase == PH_WT_FULL || s.phase == PH_CL_PART) begin
            a.flush_buffer = 1'b1;
            n.phase        = PH_CL_EMPTY;
        end else if (s.phase == PH_CD_PART) begin
            do_release(s, n, a);
        end
    endfunction

    function automatic void do_pause(input t_slot s, inout t_slot n, inout t_act a);
        if (s.phase == PH_RD_EMPTY || has_audio(s.phase)) begin
            n.paused        = 1'b1;
            a.notify_change = 1'b1;
        end
    endfunction

    function automatic void do_resume(input t_slot s, inout t_slot n, inout t_act a);
        if (s.paused) begin
            if (s.phase == PH_RD_EMPTY) begin
                n.paused        = 1'b0;
                a.notify_change = 1'b1;
            end else if (has_audio(s.phase)) begin
                n.paused        = 1'b0;
                a.wake_mixer    = 1'b1;
                a.notify_change = 1'b1;
            end
        end
    endfunction

    // fill level classes, anything at or above the buffer size is full
    assign lvl_full  = {{(LVL_CMP_W-LVL_W){1'b0}}, i_fill_level} >= BUF_LIM;
    assign lvl_empty = (i_fill_level == '0);

    // event decode
    always_comb begin
        t_slot s2;
        ns = i_slot;
        na = '0;
        ok = 1'b1;
        s2 = i_slot;
        case (i_req_type)
            REQ_START: begin
                if (i_slot.busy) begin
                    s2.restart = 1'b1;
                    ns         = s2;
                    do_stop(s2, ns, na);
                end else begin
                    ns              = SLOT_FREE;
                    ns.busy         = 1'b1;
                    na.issue_read   = 1'b1;
                    na.notify_change = 1'b1;
                end
            end
            REQ_LEVEL: begin
                if (!i_slot.busy) begin
                    ok = 1'b0;
                end else if (lvl_full) begin
                    if (i_slot.phase == PH_RD_EMPTY) begin
                        ns.phase         = PH_WT_FULL;
                        na.notify_change = 1'b1;
                        na.wake_mixer    = 1'b1;
                    end else if (i_slot.phase == PH_RD_PART) begin
                        ns.phase = PH_WT_FULL;
                    end else begin
                        ok = 1'b0;
                    end
                end else if (!lvl_empty) begin
                    if (i_slot.phase == PH_RD_EMPTY) begin
                        ns.phase         = PH_RD_PART;
                        na.notify_change = 1'b1;
                        na.wake_mixer    = 1'b1;
                    end else if (i_slot.phase == PH_WT_FULL ||
                                 i_slot.phase == PH_RD_PART) begin
                        ns.phase      = PH_RD_PART;
                        na.issue_read = 1'b1;
                    end else if (i_slot.phase != PH_CL_PART &&
                                 i_slot.phase != PH_CD_PART) begin
                        ok = 1'b0;
                    end
                end else begin
                    if (i_slot.phase == PH_RD_EMPTY || i_slot.phase == PH_WT_FULL ||
                        i_slot.phase == PH_RD_PART) begin
                        ns.phase      = PH_RD_EMPTY;
                        na.issue_read = 1'b1;
                    end else if (i_slot.phase == PH_CL_PART) begin
                        ns.phase         = PH_CL_EMPTY;
                        na.notify_change = 1'b1;
                    end else if (i_slot.phase == PH_CD_PART) begin
                        do_release(i_slot, ns, na);
                    end else begin
                        ok = 1'b0;
                    end
                end
            end
            REQ_EOF: begin
                if (!i_slot.busy) begin
                    ok = 1'b0;
                end else if (i_slot.phase == PH_WT_EOF || i_slot.phase == PH_RD_EMPTY) begin
                    ns.phase         = PH_CL_EMPTY;
                    na.request_close = 1'b1;
                end else if (i_slot.phase == PH_RD_PART) begin
                    ns.phase         = PH_CL_PART;
                    na.request_close = 1'b1;
                end else begin
                    ok = 1'b0;
                end
            end
            REQ_CLOSED: begin
                if (!i_slot.busy) begin
                    ok = 1'b0;
                end else if (i_slot.phase == PH_CL_EMPTY) begin
                    do_release(i_slot, ns, na);
                end else if (i_slot.phase == PH_CL_PART) begin
                    ns.phase = PH_CD_PART;
                end else begin
                    ok = 1'b0;
                end
            end
            REQ_PAUSE: begin
                if (i_slot.busy) begin
                    do_pause(i_slot, ns, na);
                end
            end
            REQ_RESUME: begin
                if (i_slot.busy) begin
                    do_resume(i_slot, ns, na);
                end
            end
            REQ_TOGGLE: begin
                if (i_slot.busy) begin
                    if (i_slot.paused) begin
                        do_resume(i_slot, ns, na);
                    end else begin
                        do_pause(i_slot, ns, na);
                    end
                end
            end
            REQ_STOP: begin
                if (i_slot.busy) begin
                    do_stop(i_slot, ns, na);
                end
            end
            REQ_STATUS: begin
                ok = 1'b1;
            end
            default: begin
                ok = 1'b0;
            end
        endcase

        // illegal event keeps state and raises only the error strobe, besides the status
        if (!ok) begin
            ns               = i_slot;
            na               = '0;
            na.invalid_event = 1'b1;
        end
        na.track_status = status_of(ns);

        // slot beyond the table
        if (!i_track_ok) begin
            ns               = i_slot;
            na               = '0;
            na.invalid_event = 1'b1;
        end
    end

    assign o_slot_next = ns;
    assign o_write     = i_track_ok;
    assign o_act       = na;

endmodule
